### src/srle_pkg.sv
// Shared types, register indexes and the nibble decode step for the subpicture
// RLE line decoder. No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package srle_pkg;

  localparam int CFG_IDX_W   = 3;
  localparam int POS_W       = 12;
  localparam int ARGB_W      = 32;
  localparam int NUM_COLORS  = 4;
  localparam int Q_DEPTH     = 4;
  localparam int Q_PTR_W     = 2;
  localparam int Q_CNT_W     = 3;

  localparam logic [POS_W-1:0] WIDTH_RESET = 12'd720;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_WIDTH = 3'd0,
    REG_COLOR0     = 3'd1,
    REG_COLOR1     = 3'd2,
    REG_COLOR2     = 3'd3,
    REG_COLOR3     = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       line_restart;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]  run_start;
    logic [POS_W-1:0]  run_length;
    logic [ARGB_W-1:0] run_argb;
    logic              line_done;
    logic              last;
  } out_item_t;

  // one decoded run, color still as an index
  typedef struct packed {
    logic [POS_W-1:0] start;
    logic [POS_W-1:0] length;
    logic [1:0]       cidx;
    logic             fill;
    logic             done;
  } run_t;

  // queue entry: the runs caused by one byte (at least one)
  typedef struct packed {
    run_t run0;
    run_t run1;
    logic two_runs;
  } byte_entry_t;

  // queue status toward the front end (full) and the back end
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic             hit;
    run_t             run;
    logic [11:0]      pc;
    logic [1:0]       pn;
    logic [POS_W-1:0] pos;
  } nib_step_t;

  // Add one nibble to the pending code; emit a clipped run when it completes.
  function automatic nib_step_t decode_nibble(input logic [11:0] pc,
                                              input logic [1:0] pn,
                                              input logic [3:0] nib,
                                              input logic [POS_W-1:0] pos,
                                              input logic [POS_W-1:0] width);
    nib_step_t        s;
    logic [15:0]      code;
    logic [2:0]       cnt;
    logic             complete;
    logic             fill;
    logic [POS_W-1:0] remain;
    logic [13:0]      raw;
    logic [POS_W-1:0] len;
    logic             done;
    code     = {pc, nib};
    cnt      = {1'b0, pn} + 3'd1;
    complete = ((cnt == 3'd1) && (code >= 16'h0004)) ||
               ((cnt == 3'd2) && (code >= 16'h0010)) ||
               ((cnt == 3'd3) && (code >= 16'h0040)) ||
               (cnt == 3'd4);
    fill     = (cnt == 3'd4) && (code < 16'h0010);
    remain   = width - pos;
    raw      = code[15:2];
    if (fill || (raw > {2'b00, remain})) begin
      len = remain;
    end else begin
      len = raw[POS_W-1:0];
    end
    done = (len == remain);
    s.run.start  = pos;
    s.run.length = len;
    s.run.cidx   = code[1:0];
    s.run.fill   = fill;
    s.run.done   = done;
    if (complete) begin
      s.hit = 1'b1;
      s.pc  = '0;
      s.pn  = '0;
      s.pos = done ? '0 : (pos + len);
    end else begin
      s.hit = 1'b0;
      s.pc  = code[11:0];
      s.pn  = cnt[1:0];
      s.pos = pos;
    end
    return s;
  endfunction

endpackage

### src/srle_front.sv
// Front end: accepts RLE bytes, assembles codes and computes clipped runs.
// Depends on srle_pkg; pushes one entry per byte that yields runs.
`timescale 1ns / 1ps
module srle_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  srle_pkg::in_item_t         in_data,
  input  logic [srle_pkg::POS_W-1:0] width,
  input  logic                       q_full,
  output logic                       push,
  output srle_pkg::byte_entry_t      push_entry
);

  logic [11:0]                pc_r, pc_nxt;
  logic [1:0]                 pn_r, pn_nxt;
  logic [srle_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [11:0]                pc0;
  logic [1:0]                 pn0;
  logic [srle_pkg::POS_W-1:0] pos0;
  srle_pkg::nib_step_t        s0, s1;
  logic                       accept;
  logic                       use_s1;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  // restart and line wrap, then two nibble steps
  always_comb begin
    pc0  = in_data.line_restart ? 12'd0 : pc_r;
    pn0  = in_data.line_restart ? 2'd0  : pn_r;
    pos0 = in_data.line_restart ? '0    : pos_r;
    if (pos0 >= width) begin
      pos0 = '0;
    end
    s0     = srle_pkg::decode_nibble(pc0, pn0, in_data.data_byte[7:4], pos0, width);
    s1     = srle_pkg::decode_nibble(s0.pc, s0.pn, in_data.data_byte[3:0], s0.pos, width);
    // low nibble is dropped once the line is complete
    use_s1 = !(s0.hit && s0.run.done);
  end

  // next state and queue entry
  always_comb begin
    if (use_s1) begin
      pc_nxt  = s1.pc;
      pn_nxt  = s1.pn;
      pos_nxt = s1.pos;
    end else begin
      pc_nxt  = s0.pc;
      pn_nxt  = s0.pn;
      pos_nxt = s0.pos;
    end
    push_entry.run0     = s0.hit ? s0.run : s1.run;
    push_entry.run1     = s1.run;
    push_entry.two_runs = s0.hit && use_s1 && s1.hit;
    push                = accept && (s0.hit || (use_s1 && s1.hit));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= '0;
      pn_r  <= '0;
      pos_r <= '0;
    end else if (accept) begin
      pc_r  <= pc_nxt;
      pn_r  <= pn_nxt;
      pos_r <= pos_nxt;
    end
  end

  // an empty pending count holds no code bits
  a_pending_clear: assert property (@(posedge clk) disable iff (!rst_n)
    pn_r == 2'd0 |-> pc_r == 12'd0)
    else $error("pending code bits without pending nibbles");

  // a completed line always returns the position to zero
  a_line_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    push && (push_entry.two_runs ? push_entry.run1.done : push_entry.run0.done)
    |=> pos_r == '0)
    else $error("position not cleared after line end");

endmodule

### src/srle_fifo.sv
// Short queue of per-byte run entries between front and back end.
// Depends on srle_pkg for the entry type and depth constants.
`timescale 1ns / 1ps
module srle_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  srle_pkg::byte_entry_t push_entry,
  input  logic                  pop,
  output srle_pkg::byte_entry_t head,
  output srle_pkg::q_stat_t     stat
);

  srle_pkg::byte_entry_t        mem_r [srle_pkg::Q_DEPTH];
  logic [srle_pkg::Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [srle_pkg::Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == srle_pkg::Q_CNT_W'(srle_pkg::Q_DEPTH));
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    stat.full |-> !push || pop)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("queue read while empty");

endmodule

### src/srle_back.sv
// Back end: serializes the runs of each queued byte into the output register
// and applies the color table. Depends on srle_pkg.
`timescale 1ns / 1ps
module srle_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  srle_pkg::byte_entry_t       head,
  input  srle_pkg::q_stat_t           stat,
  output logic                        pop,
  input  logic [srle_pkg::NUM_COLORS-1:0][srle_pkg::ARGB_W-1:0] colors,
  output logic                        out_valid,
  input  logic                        out_stall,
  output srle_pkg::out_item_t         out_data
);

  logic                out_valid_r;
  srle_pkg::out_item_t out_data_r, out_data_nxt;
  logic                sel_r;
  logic                load;
  srle_pkg::run_t      cur;
  logic                cur_last;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign load      = !out_valid_r || !out_stall;

  // pick the run in turn and format it
  always_comb begin
    cur      = sel_r ? head.run1 : head.run0;
    cur_last = sel_r || !head.two_runs;
    out_data_nxt.run_start  = cur.start;
    out_data_nxt.run_length = cur.length;
    out_data_nxt.run_argb   = cur.fill ? '0 : colors[cur.cidx];
    out_data_nxt.line_done  = cur.done;
    out_data_nxt.last       = cur_last;
    pop = load && !stat.empty && cur_last;
  end

  always_ff @(posedge clk) begin
    if (load && !stat.empty) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sel_r       <= 1'b0;
    end else if (load) begin
      out_valid_r <= !stat.empty;
      if (!stat.empty) begin
        sel_r <= !cur_last;
      end
    end
  end

  // second run is only pending on a two-run entry still in the queue
  a_sel_valid: assert property (@(posedge clk) disable iff (!rst_n)
    sel_r |-> !stat.empty && head.two_runs)
    else $error("second run selected without a two-run entry");

endmodule

### src/subpicture_rle_line_decoder_core.sv
// Top level of the subpicture RLE line decoder: configuration registers,
// front end, run queue and back end. Depends on srle_pkg and the srle_* modules.
//
//   channel   dir  handshake          payload
//   in_       in   in_valid/in_stall  srle_pkg::in_item_t (RLE byte, restart)
//   out_      out  out_valid/out_stall srle_pkg::out_item_t (one run)
//   cfg_      in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// One byte is accepted per cycle while in_stall is low; its runs pass through
// the run queue into the output register. A byte yielding two runs occupies the
// single output register once per run; the four-entry run queue absorbs that.
// Reset (rst_n low, synchronous) clears code state, position, queue and
// output valid; width returns to 720 and colors to zero.
// in_stall rises only when the run queue is full; cfg_ready is always high.
`timescale 1ns / 1ps
module subpicture_rle_line_decoder_core #(
  parameter int MAX_LINE_WIDTH = 4095
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  srle_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output srle_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [srle_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [srle_pkg::ARGB_W-1:0]       cfg_data
);

  logic [srle_pkg::POS_W-1:0] width_r;
  logic [srle_pkg::NUM_COLORS-1:0][srle_pkg::ARGB_W-1:0] colors_r;
  logic [srle_pkg::POS_W-1:0] eff_width;
  logic                       push, pop;
  srle_pkg::byte_entry_t      push_entry, head;
  srle_pkg::q_stat_t          stat;

  assign cfg_ready = 1'b1;

  // clamp width to 1..MAX_LINE_WIDTH
  always_comb begin
    if (width_r == '0) begin
      eff_width = srle_pkg::POS_W'(1);
    end else if (width_r > srle_pkg::POS_W'(MAX_LINE_WIDTH)) begin
      eff_width = srle_pkg::POS_W'(MAX_LINE_WIDTH);
    end else begin
      eff_width = width_r;
    end
  end

  // configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= srle_pkg::WIDTH_RESET;
      colors_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        srle_pkg::REG_LINE_WIDTH: width_r     <= cfg_data[srle_pkg::POS_W-1:0];
        srle_pkg::REG_COLOR0:     colors_r[0] <= cfg_data;
        srle_pkg::REG_COLOR1:     colors_r[1] <= cfg_data;
        srle_pkg::REG_COLOR2:     colors_r[2] <= cfg_data;
        srle_pkg::REG_COLOR3:     colors_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  srle_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .width      (eff_width),
    .q_full     (stat.full),
    .push       (push),
    .push_entry (push_entry)
  );

  srle_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (stat)
  );

  srle_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .stat      (stat),
    .pop       (pop),
    .colors    (colors_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
